// ===== rtl/core/rid_pkg.sv =====
// Shared types and constants for the run-length image decoder.
`timescale 1ns / 1ps

package rid_pkg;

   localparam int PIXEL_COUNT_WIDTH_DEFAULT = 24;

   localparam int BYTE_W      = 8;
   localparam int PIXEL_W     = 32;
   localparam int COUNT_W     = 8;
   localparam int BPP_W       = 3;
   localparam int TOTAL_W     = 24;
   localparam int BYTE_IDX_W  = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 24;

   // Header codes: below the threshold is a raw packet of header+1 pixels,
   // at or above it a run of header-RUN_BIAS copies.
   localparam logic [BYTE_W-1:0] RUN_HEADER_MIN = 8'd128;
   localparam logic [BYTE_W-1:0] RUN_BIAS       = 8'd127;

   localparam logic [BPP_W-1:0]   BPP_RESET    = 3'd4;
   localparam logic [BPP_W-1:0]   BPP_MIN      = 3'd1;
   localparam logic [BPP_W-1:0]   BPP_MAX      = 3'd4;
   localparam logic [TOTAL_W-1:0] TOTAL_RESET  = 24'd1;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_PIXEL = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL_PIXELS    = 1'b1;

   // Packet and pixel assembly state
   typedef struct packed {
      logic                  expect_header;
      logic                  run_packet;
      logic [COUNT_W-1:0]    pkt_left;
      logic [BYTE_IDX_W-1:0] byte_idx;
      logic [PIXEL_W-1:0]    assembly;
   } rid_state_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_value;
      logic [COUNT_W-1:0] repeat_count;
      logic               status;
      logic               image_complete;
   } rid_token_type;

   localparam rid_state_type STATE_CLEAR = '{
      expect_header: 1'b1,
      run_packet:    1'b0,
      pkt_left:      '0,
      byte_idx:      '0,
      assembly:      '0
   };

endpackage

// ===== rtl/core/rid_step.sv =====
// Per-byte decode logic: header parse, pixel assembly, token and counter update.
`timescale 1ns / 1ps

module rid_step #(
   parameter int PIXEL_COUNT_WIDTH = rid_pkg::PIXEL_COUNT_WIDTH_DEFAULT
) (
   input  rid_pkg::rid_state_type         state_cur,
   input  logic [PIXEL_COUNT_WIDTH-1:0]   decoded_cur,
   input  logic                           halted_cur,
   input  logic [rid_pkg::BPP_W-1:0]      bytes_per_pixel,
   input  logic [rid_pkg::TOTAL_W-1:0]    total_pixels,
   input  logic [rid_pkg::BYTE_W-1:0]     data_byte,
   input  logic                           start_of_image,
   output rid_pkg::rid_state_type         state_nxt,
   output logic [PIXEL_COUNT_WIDTH-1:0]   decoded_nxt,
   output logic                           halted_nxt,
   output logic                           has_token,
   output rid_pkg::rid_token_type         token
);

   localparam int PW = PIXEL_COUNT_WIDTH;

   logic [PW-1:0]                  limit;
   rid_pkg::rid_state_type         st;
   logic [PW-1:0]                  decoded;
   logic                           halted;
   logic [rid_pkg::BPP_W-1:0]      pix_size;
   logic [rid_pkg::PIXEL_W-1:0]    assembled;
   logic [rid_pkg::BPP_W-1:0]      byte_next;
   logic [PW-1:0]                  remaining;
   logic [PW-1:0]                  demand;
   logic                           overflow;
   logic [rid_pkg::COUNT_W-1:0]    count;
   logic [PW-1:0]                  decoded_sum;

   // Limit saturates to the counter range
   generate
      if (PW >= rid_pkg::TOTAL_W) begin : g_lim_wide
         assign limit = PW'(total_pixels);
      end else begin : g_lim_narrow
         assign limit = ((total_pixels >> PW) != '0) ? '1 : total_pixels[PW-1:0];
      end
   endgenerate

   always_comb begin
      if (bytes_per_pixel < rid_pkg::BPP_MIN) begin
         pix_size = rid_pkg::BPP_MIN;
      end else if (bytes_per_pixel > rid_pkg::BPP_MAX) begin
         pix_size = rid_pkg::BPP_MAX;
      end else begin
         pix_size = bytes_per_pixel;
      end
   end

   // Start of image clears before the byte is looked at
   assign st      = start_of_image ? rid_pkg::STATE_CLEAR : state_cur;
   assign decoded = start_of_image ? '0 : decoded_cur;
   assign halted  = start_of_image ? 1'b0 : halted_cur;

   assign assembled = st.assembly
                    | (rid_pkg::PIXEL_W'(data_byte) << {st.byte_idx, 3'b000});
   assign byte_next = rid_pkg::BPP_W'(st.byte_idx) + 3'd1;

   assign remaining   = limit - decoded;
   assign demand      = PW'(st.pkt_left);
   assign overflow    = demand > remaining;
   assign count       = !st.run_packet ? rid_pkg::COUNT_W'(1)
                      : overflow        ? remaining[rid_pkg::COUNT_W-1:0]
                      :                   st.pkt_left;
   assign decoded_sum = decoded + PW'(count);

   always_comb begin
      state_nxt   = st;
      decoded_nxt = decoded;
      halted_nxt  = halted;
      has_token   = 1'b0;
      token.pixel_value    = assembled;
      token.repeat_count   = count;
      token.status         = overflow;
      token.image_complete = (decoded_sum == limit);

      if (halted || (decoded >= limit)) begin
         // ignored byte
      end else if (st.expect_header) begin
         state_nxt.expect_header = 1'b0;
         state_nxt.run_packet    = (data_byte >= rid_pkg::RUN_HEADER_MIN);
         state_nxt.pkt_left      = (data_byte >= rid_pkg::RUN_HEADER_MIN)
                                 ? data_byte - rid_pkg::RUN_BIAS
                                 : data_byte + 8'd1;
         state_nxt.byte_idx      = '0;
         state_nxt.assembly      = '0;
      end else if (byte_next < pix_size) begin
         state_nxt.assembly = assembled;
         state_nxt.byte_idx = byte_next[rid_pkg::BYTE_IDX_W-1:0];
      end else begin
         has_token   = 1'b1;
         decoded_nxt = decoded_sum;
         if (st.run_packet || overflow || (st.pkt_left <= 8'd1)) begin
            state_nxt.pkt_left      = '0;
            state_nxt.expect_header = 1'b1;
         end else begin
            state_nxt.pkt_left = st.pkt_left - 8'd1;
         end
         if (overflow) begin
            halted_nxt = 1'b1;
         end
         state_nxt.byte_idx = '0;
         state_nxt.assembly = '0;
      end
   end

endmodule

// ===== rtl/core/rid_out_buf.sv =====
// Two-entry token buffer: output register plus skid stage.
`timescale 1ns / 1ps

module rid_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rid_pkg::rid_token_type push_token,
   output logic                   can_accept,
   output logic                   out_valid,
   input  logic                   out_ready,
   output rid_pkg::rid_token_type out_token,
   output logic                   skid_busy
);

   logic                   main_valid_ff, main_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   rid_pkg::rid_token_type main_ff, main_in;
   rid_pkg::rid_token_type skid_ff, skid_in;
   logic                   pop;

   assign pop        = main_valid_ff && out_ready;
   assign can_accept = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_token  = main_ff;
   assign skid_busy  = skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_in       = push_token;
            skid_valid_in = 1'b1;
         end else begin
            main_in       = push_token;
            main_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== rtl/core/rle_image_decoder.sv =====
// Top level of the run-length image stream decoder.
`timescale 1ns / 1ps
// Decodes a run-length coded image stream, one byte per request.
// Slave side: req_tdata carries the stream byte, req_tuser marks start of
// image (counters and packet phase cleared, byte taken as a header).
// Master side: one token per finished pixel: pixel value and repeat count in
// rsp_tdata, overflow flag in rsp_tuser, rsp_tlast on the token that brings
// the decoded count up to total_pixels.
// Header bytes, bytes after completion and bytes while halted give no token.
// Throughput: one request per cycle while the skid stage is free; decode is a single pass of
// logic from the state registers into the token register.
// Output: a finished token is registered, into the skid stage if the output register is held.
// Stall: the output register plus a one-entry skid stage absorb a stalled
// receiver; req_tready drops only once the skid stage holds a token.
// Reset: bytes_per_pixel 4, total_pixels 1, decode state cleared, both token
// stages emptied. No clearing pass; requests are taken the cycle after reset.
// Configuration via csr_we/csr_index/csr_wdata, takes effect next cycle,
// decode state kept. Overflow halts decode until the next start of image.
module rle_image_decoder #(
   parameter int PIXEL_COUNT_WIDTH = rid_pkg::PIXEL_COUNT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // data_byte
   input  logic                              req_tuser,  // start_of_image
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0]                       rsp_tdata,  // pixel_value, repeat_count
   output logic                              rsp_tuser,  // status
   output logic                              rsp_tlast,  // image_complete
   input  logic                              csr_we,
   input  logic [rid_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rid_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int PW = PIXEL_COUNT_WIDTH;

   // configuration
   logic [rid_pkg::BPP_W-1:0]   bpp_ff;
   logic [rid_pkg::TOTAL_W-1:0] total_ff;

   // decode state
   rid_pkg::rid_state_type state_ff, state_in;
   logic [PW-1:0]          decoded_ff, decoded_in;
   logic                   halted_ff, halted_in;

   logic                   req_accept;
   logic                   has_token;
   rid_pkg::rid_token_type token;
   rid_pkg::rid_token_type out_token;
   logic                   skid_busy;

   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff   <= rid_pkg::BPP_RESET;
         total_ff <= rid_pkg::TOTAL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rid_pkg::CSR_BYTES_PER_PIXEL: bpp_ff   <= csr_wdata[rid_pkg::BPP_W-1:0];
            rid_pkg::CSR_TOTAL_PIXELS:    total_ff <= csr_wdata[rid_pkg::TOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   rid_step #(
      .PIXEL_COUNT_WIDTH(PW)
   ) u_step (
      .state_cur       (state_ff),
      .decoded_cur     (decoded_ff),
      .halted_cur      (halted_ff),
      .bytes_per_pixel (bpp_ff),
      .total_pixels    (total_ff),
      .data_byte       (req_tdata),
      .start_of_image  (req_tuser),
      .state_nxt       (state_in),
      .decoded_nxt     (decoded_in),
      .halted_nxt      (halted_in),
      .has_token       (has_token),
      .token           (token)
   );

   // state moves only on an accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rid_pkg::STATE_CLEAR;
         decoded_ff <= '0;
         halted_ff  <= 1'b0;
      end else if (req_accept) begin
         state_ff   <= state_in;
         decoded_ff <= decoded_in;
         halted_ff  <= halted_in;
      end
   end

   rid_out_buf u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept && has_token),
      .push_token (token),
      .can_accept (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_token  (out_token),
      .skid_busy  (skid_busy)
   );

   assign rsp_tdata = {out_token.repeat_count, out_token.pixel_value};
   assign rsp_tuser = out_token.status;
   assign rsp_tlast = out_token.image_complete;

   // skid stage only fills behind a held output register
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_busy |-> rsp_tvalid)
      else $error("skid stage full while output register empty");

   // no token while halted unless a new image starts
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && halted_ff && !req_tuser) |-> !has_token)
      else $error("token produced while halted");

   // every token carries a nonzero repeat count
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[39:32] != 8'd0))
      else $error("token with zero repeat count");

   // an overflow token always halts the decoder
   a_overflow_halts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && has_token && token.status) |=> halted_ff)
      else $error("overflow without halt");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the run-length image decoder.
`timescale 1ns / 1ps

// Drives coded image streams into the decoder and checks every token that comes back
// against a cycle-free software predictor kept in step with accepted requests.
//
// Flow
//  - the stimulus block fills a queue of pending requests; a clocked driver presents them
//    on the req_ side, with random idle bursts
//  - every request accepted by the decoder is fed to the predictor, which queues the token
//    (if any) that the byte should cause
//  - a clocked monitor pops the oldest expected token for each token accepted on rsp_ and
//    compares pixel, count, overflow and completion flags
//  - the receiver stalls in random bursts as well; the final phase runs with no idling
//
// Registers are only written with the decoder idle: every queued request taken, every
// expected token seen, then a short drain since a header byte leaves no token to wait on.
// The decode state is deliberately left mid-pixel across one write, to see the pixel
// finish at the new size.

module tb_top;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 3;
   // drain for the output register plus the skid stage
   localparam int DRAIN_CYCLES   = 4;
   // far beyond the longest quiet stretch of a correct run (idle bursts, drain, csr writes)
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 9;
   localparam int PHASE_REQS     = 55;

   typedef struct packed {
      logic                       sof;
      logic [rid_pkg::BYTE_W-1:0] data;
   } stream_req_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata  = '0;  // data_byte
   logic                            req_tuser  = 1'b0; // start_of_image
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [39:0]                     rsp_tdata;        // pixel_value, repeat_count
   logic                            rsp_tuser;        // status
   logic                            rsp_tlast;        // image_complete
   logic                            csr_we     = 1'b0;
   logic [rid_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [rid_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;

   // pending requests and expected tokens
   stream_req_type         pending_reqs[$];
   rid_pkg::rid_token_type expected_tokens[$];
   int unsigned   reqs_queued = 0;
   int unsigned   reqs_taken  = 0;
   int unsigned   mismatches  = 0;

   // idling controls, set per phase by the stimulus block
   int unsigned gap_pct   = 0;
   int unsigned stall_pct = 0;
   bit          no_idle   = 1'b0;
   int unsigned gap_left  = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;

   // predictor copy of the registers
   logic [rid_pkg::BPP_W-1:0]   cfg_bpp;
   logic [rid_pkg::TOTAL_W-1:0] cfg_total;

   // predictor copy of the decode state; the pixel counter is as wide as the total
   // register, so the limit never saturates below the total
   logic                           hdr_wait;
   logic                           is_run;
   logic [rid_pkg::COUNT_W-1:0]    pkt_remaining;
   logic [rid_pkg::BYTE_IDX_W-1:0] byte_pos;
   logic [rid_pkg::PIXEL_W-1:0]    pix_acc;
   logic [rid_pkg::TOTAL_W-1:0]    px_done;
   logic                           stopped;

   rle_image_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // out-of-range sizes: 0 behaves as 1, 5..7 as 4
   function automatic int unsigned pixel_bytes(input logic [rid_pkg::BPP_W-1:0] v);
      if (v < rid_pkg::BPP_MIN) return 32'(rid_pkg::BPP_MIN);
      if (v > rid_pkg::BPP_MAX) return 32'(rid_pkg::BPP_MAX);
      return 32'(v);
   endfunction

   task automatic clear_decode_state();
      hdr_wait      = 1'b1;
      is_run        = 1'b0;
      pkt_remaining = '0;
      byte_pos      = '0;
      pix_acc       = '0;
      px_done       = '0;
      stopped       = 1'b0;
   endtask

   // Advance the decode state by one accepted byte; queue the token it finishes, if any.
   task automatic decode_stream_byte(input logic [rid_pkg::BYTE_W-1:0] b, input logic sof);
      logic [rid_pkg::TOTAL_W-1:0] room;
      logic [rid_pkg::TOTAL_W-1:0] cnt;
      logic                        ovf;
      rid_pkg::rid_token_type      tok;
      if (sof) clear_decode_state();
      // halted after an overflow, or image done (a zero total counts as done at once)
      if (stopped || px_done >= cfg_total) return;
      if (hdr_wait) begin
         is_run        = (b >= rid_pkg::RUN_HEADER_MIN);
         pkt_remaining = is_run ? b - rid_pkg::RUN_BIAS : b + 8'd1;
         hdr_wait      = 1'b0;
         byte_pos      = '0;
         pix_acc       = '0;
         return;
      end
      pix_acc = pix_acc | ({24'd0, b} << (8 * byte_pos));
      if (byte_pos + 1 < pixel_bytes(cfg_bpp)) begin
         byte_pos = byte_pos + 1'b1;
         return;
      end
      room = cfg_total - px_done;
      ovf  = (rid_pkg::TOTAL_W'(pkt_remaining) > room);
      // a raw pixel keeps count 1 even when clipped
      if (!is_run) cnt = rid_pkg::TOTAL_W'(1);
      else if (ovf) cnt = room;
      else cnt = rid_pkg::TOTAL_W'(pkt_remaining);
      px_done = px_done + cnt;

      tok.pixel_value    = pix_acc;
      tok.repeat_count   = cnt[rid_pkg::COUNT_W-1:0];
      tok.status         = ovf;
      tok.image_complete = (px_done == cfg_total);
      expected_tokens.push_back(tok);

      if (is_run || ovf || pkt_remaining <= 8'd1) pkt_remaining = '0;
      else pkt_remaining = pkt_remaining - 1'b1;
      if (pkt_remaining == '0) hdr_wait = 1'b1;
      if (ovf) stopped = 1'b1;
      byte_pos = '0;
      pix_acc  = '0;
   endtask

   task automatic note_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   // ---------------------------------------------------------------- request side

   // Presents pending requests; a held request stays put until taken.
   always @(posedge clock) begin : req_driver
      stream_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 99) < gap_pct) begin
            // burst of idle cycles, this one included
            gap_left = $urandom_range(0, 17);
            req_tvalid <= 1'b0;
         end else begin
            nxt = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= nxt.data;
            req_tuser  <= nxt.sof;
         end
      end
   end

   // Every accepted request goes through the predictor.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         decode_stream_byte(req_tdata, req_tuser);
         reqs_taken++;
      end
   end

   // ---------------------------------------------------------------- token side

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < stall_pct) begin
         hold_left = $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : token_check
      rid_pkg::rid_token_type got;
      rid_pkg::rid_token_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pixel_value    = rsp_tdata[rid_pkg::PIXEL_W-1:0];
         got.repeat_count   = rsp_tdata[rid_pkg::PIXEL_W +: rid_pkg::COUNT_W];
         got.status         = rsp_tuser;
         got.image_complete = rsp_tlast;
         if (expected_tokens.size() == 0) begin
            note_mismatch($sformatf("token with nothing expected: pixel %h count %0d",
                                    got.pixel_value, got.repeat_count));
         end else begin
            want = expected_tokens.pop_front();
            if (got.pixel_value !== want.pixel_value)
               note_mismatch($sformatf("pixel_value %h, expected %h",
                                       got.pixel_value, want.pixel_value));
            if (got.repeat_count !== want.repeat_count)
               note_mismatch($sformatf("repeat_count %0d, expected %0d",
                                       got.repeat_count, want.repeat_count));
            if (got.status !== want.status)
               note_mismatch($sformatf("status %b, expected %b", got.status, want.status));
            if (got.image_complete !== want.image_complete)
               note_mismatch($sformatf("image_complete %b, expected %b",
                                       got.image_complete, want.image_complete));
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   // counts cycles in which neither side moves a request or a token
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[rle_image_decoder] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_req(input logic [rid_pkg::BYTE_W-1:0] d, input logic s);
      stream_req_type r;
      r.data = d;
      r.sof  = s;
      pending_reqs.push_back(r);
      reqs_queued++;
   endtask

   // all requests taken, all tokens seen, then a drain for a trailing header byte
   task automatic wait_idle();
      while (reqs_taken != reqs_queued || expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write; the predictor copy follows at once since the decoder is idle
   task automatic csr_write(input logic [rid_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [rid_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == rid_pkg::CSR_BYTES_PER_PIXEL) cfg_bpp = data[rid_pkg::BPP_W-1:0];
      else cfg_total = data[rid_pkg::TOTAL_W-1:0];
   endtask

   // size word with junk in the unused upper bits
   function automatic logic [rid_pkg::CSR_DATA_W-1:0] bpp_word(
         input logic [rid_pkg::BPP_W-1:0] v);
      logic [rid_pkg::CSR_DATA_W-1:0] w;
      w = rid_pkg::CSR_DATA_W'($urandom);
      w[rid_pkg::BPP_W-1:0] = v;
      return w;
   endfunction

   initial begin : stimulus
      int unsigned idle_mix[4];
      int unsigned phase_base;
      int unsigned left;
      int unsigned npix;
      int unsigned n;
      int unsigned bsz;
      logic [rid_pkg::TOTAL_W-1:0] tot;
      logic [rid_pkg::BYTE_W-1:0]  hdr;
      bit spill;
      bit run;
      bit first;

      idle_mix = '{0, 8, 25, 50};
      cfg_bpp   = rid_pkg::BPP_RESET;
      cfg_total = rid_pkg::TOTAL_RESET;
      clear_decode_state();
      gap_pct   = 20;
      stall_pct = 20;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset values: 4-byte pixels, a one-pixel image
      push_req(8'd128, 1'b1);
      push_req(8'h00, 1'b0);
      push_req(8'hFF, 1'b0);
      push_req(8'h00, 1'b0);
      push_req(8'hFF, 1'b0);

      // gray pixels, three-pixel image
      wait_idle();
      csr_write(rid_pkg::CSR_BYTES_PER_PIXEL, bpp_word(rid_pkg::BPP_MIN));
      csr_write(rid_pkg::CSR_TOTAL_PIXELS, 24'd3);
      push_req(8'd0, 1'b1);     // smallest raw packet
      push_req(8'h00, 1'b0);
      push_req(8'd128, 1'b0);   // smallest run
      push_req(8'hFF, 1'b0);
      push_req(8'd255, 1'b0);   // longest run passes the image end: clipped, halts
      push_req(8'hA5, 1'b0);
      push_req(8'h12, 1'b0);    // ignored while halted
      push_req(8'd127, 1'b1);   // longest raw packet, overflows on its first pixel
      push_req(8'h80, 1'b0);
      push_req(8'h7F, 1'b0);    // ignored

      // zero size acts as one; zero total means nothing is decoded
      wait_idle();
      csr_write(rid_pkg::CSR_BYTES_PER_PIXEL, bpp_word('0));
      csr_write(rid_pkg::CSR_TOTAL_PIXELS, '0);
      push_req(8'h81, 1'b1);
      push_req(8'h33, 1'b0);

      // oversize setting acts as four; stop half way through a pixel
      wait_idle();
      csr_write(rid_pkg::CSR_BYTES_PER_PIXEL, bpp_word(3'd7));
      csr_write(rid_pkg::CSR_TOTAL_PIXELS, 24'hFFFFFF);
      push_req(8'd0, 1'b1);
      push_req(8'h11, 1'b0);
      push_req(8'h22, 1'b0);

      // shrink the pixel: the next byte finishes it; then a start inside a raw packet
      wait_idle();
      csr_write(rid_pkg::CSR_BYTES_PER_PIXEL, bpp_word(3'd2));
      push_req(8'h33, 1'b0);
      push_req(8'd3, 1'b0);
      push_req(8'h44, 1'b0);
      push_req(8'h55, 1'b0);
      push_req(8'h85, 1'b1);
      push_req(8'h66, 1'b0);
      push_req(8'h77, 1'b0);

      // random phases: mostly well-formed images, some noise
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         if ($urandom_range(0, 4) == 0)
            csr_write(rid_pkg::CSR_BYTES_PER_PIXEL,
                      bpp_word(rid_pkg::BPP_W'($urandom_range(0, 7))));
         else
            csr_write(rid_pkg::CSR_BYTES_PER_PIXEL,
                      bpp_word(rid_pkg::BPP_W'($urandom_range(rid_pkg::BPP_MIN,
                                                               rid_pkg::BPP_MAX))));
         if (ph == 0) tot = 24'd1;
         else if (ph == 1) tot = 24'hFFFFFF;
         else if ($urandom_range(0, 3) < 2) tot = rid_pkg::TOTAL_W'($urandom_range(2, 40));
         else if ($urandom_range(0, 1) == 0)
            tot = rid_pkg::TOTAL_W'($urandom_range(41, 400));
         else tot = rid_pkg::TOTAL_W'($urandom_range(401, 24'hFFFFFF));
         csr_write(rid_pkg::CSR_TOTAL_PIXELS, tot);

         no_idle   = (ph == RANDOM_PHASES - 1);
         gap_pct   = idle_mix[$urandom_range(0, 3)];
         stall_pct = idle_mix[$urandom_range(0, 3)];
         bsz       = pixel_bytes(cfg_bpp);
         phase_base = reqs_queued;

         while (reqs_queued - phase_base < PHASE_REQS) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise, the odd byte flagged as a start
               repeat ($urandom_range(1, 6))
                  push_req(rid_pkg::BYTE_W'($urandom_range(0, 255)),
                           $urandom_range(0, 7) == 0);
            end else begin
               // an image; large totals are never finished, a few images stop short
               if (tot > 400) npix = $urandom_range(1, 300);
               else if ($urandom_range(0, 4) == 0) npix = $urandom_range(1, tot);
               else npix = tot;
               spill = ($urandom_range(0, 4) == 0);
               left  = npix;
               first = 1'b1;
               while (left > 0) begin
                  run = $urandom_range(0, 1);
                  // raw packets kept short so the byte count stays sane
                  n = $urandom_range(1, run ? (left < 128 ? left : 128) : (left < 6 ? left : 6));
                  // last packet asks for more than is left
                  if (spill && n == left && left < 128)
                     n = $urandom_range(left + 1, (run || left + 3 > 128) ? 128 : left + 3);
                  hdr = rid_pkg::BYTE_W'(run ? 32'(rid_pkg::RUN_BIAS) + n : n - 1);
                  push_req(hdr, first);
                  first = 1'b0;
                  repeat ((run ? 1 : n) * bsz)
                     push_req(rid_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
                  left = (n >= left) ? 0 : left - n;
               end
               // stray byte after the image
               if ($urandom_range(0, 3) == 0)
                  push_req(rid_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
            end
         end
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("[rle_image_decoder] OK");
      end else begin
         $display("[rle_image_decoder] ERROR");
      end
      $finish;
   end

endmodule
